### design/scale_step_sequencer_glide_core_macros.svh
// Assertion macros for the scale step sequencer core.
// Depends on nothing; included by the top level only.
`ifndef SCALE_STEP_SEQUENCER_GLIDE_CORE_MACROS_SVH
`define SCALE_STEP_SEQUENCER_GLIDE_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Consequent must hold in the same cycle as the antecedent
`define SSG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ssg check failed");
// Consequent must hold in the cycle after the antecedent
`define SSG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ssg check failed");
`else
`define SSG_ASSERT_SAME(label, clk, rst, ante, cons)
`define SSG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

### design/ssg_pkg.sv
// Shared types and constants of the scale step sequencer core.
// Depends on nothing.
package ssg_pkg;

  localparam int DefNumSteps  = 32;
  localparam int DefNumScales = 8;
  localparam int DefNumNotes  = 128;

  // item kinds
  localparam logic [2:0] KindLoadStep  = 3'd0;
  localparam logic [2:0] KindLoadScale = 3'd1;
  localparam logic [2:0] KindNoteOn    = 3'd2;
  localparam logic [2:0] KindPosition  = 3'd3;
  localparam logic [2:0] KindGlide     = 3'd4;

  // measure modes
  localparam logic [1:0] ModeBeats = 2'd0;
  localparam logic [1:0] ModeBars  = 2'd1;
  localparam logic [1:0] ModeNotes = 2'd2;
  localparam logic [1:0] ModeFirst = 2'd3;

  // configuration register indexes
  localparam logic [2:0] RegMeasureMode   = 3'd0;
  localparam logic [2:0] RegLoopLength    = 3'd1;
  localparam logic [2:0] RegStepLength    = 3'd2;
  localparam logic [2:0] RegPositionOfs   = 3'd3;
  localparam logic [2:0] RegGlideFactor   = 3'd4;

  // snap threshold of a glide tick, in LSB
  localparam logic [31:0] SnapLimit = 32'd7;
  // quotient bits of the position division
  localparam int DivBits = 25;

  typedef struct packed {
    logic [2:0]         kind;
    logic [6:0]         slot;
    logic [3:0]         scale_number;
    logic [31:0]        frequency_value;
    logic signed [31:0] beat_position;
    logic signed [23:0] bar_position;
  } in_t;

  typedef struct packed {
    logic [5:0]  step_number;
    logic [6:0]  note;
    logic [31:0] frequency;
    logic        position_negative;
  } out_t;

endpackage

### design/scale_step_sequencer_glide_core.sv
// Loads and a note-on without step change pass ST_EXEC, ST_RD and ST_RDW; a glide
// tick adds ST_GRD, ST_GMUL, ST_GWR; a step change adds ST_SEL, after the bit-serial
// divide and modulo in ST_DIV unless in ModeFirst. One item at a time; busy stays
// high until the result. The result strobe lasts one cycle and cannot stall.
// Synchronous reset clears step table and step, sets active scale to one and the
// configuration registers to defaults; scale and frequency memories are undefined
// until written. Top level of the scale step sequencer; uses ssg_pkg and the macro header.
`include "scale_step_sequencer_glide_core_macros.svh"
module scale_step_sequencer_glide_core #(
  parameter int NUM_STEPS  = ssg_pkg::DefNumSteps,
  parameter int NUM_SCALES = ssg_pkg::DefNumScales,
  parameter int NUM_NOTES  = ssg_pkg::DefNumNotes
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  input  ssg_pkg::in_t  item,
  output logic          result_valid,
  output ssg_pkg::out_t result,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [2:0]    cfg_index,
  input  logic [31:0]   cfg_data
);

  localparam int SIW = $clog2(NUM_STEPS);
  localparam int NIW = $clog2(NUM_NOTES);
  localparam int SAW = $clog2(NUM_SCALES * NUM_NOTES);

  typedef enum logic [3:0] {
    ST_IDLE, ST_EXEC, ST_DIV, ST_SEL, ST_GRD, ST_GMUL, ST_GWR, ST_RD, ST_RDW
  } state_t;

  state_t state;
  ssg_pkg::in_t it;

  // configuration registers
  logic [1:0]  measure_mode;
  logic [5:0]  loop_length;
  logic [6:0]  step_length;
  logic [16:0] position_offset;
  logic [15:0] glide_factor;

  logic [3:0] step_table [NUM_STEPS];
  logic [5:0] step_position;
  logic [3:0] active_scale;
  logic       neg;

  // memories
  logic [31:0] scale_mem [NUM_SCALES * NUM_NOTES];
  logic [31:0] freq_mem  [NUM_NOTES];
  logic [31:0] scale_rd, freq_rd;

  // divide and modulo unit
  logic [24:0] dvd;
  logic [6:0]  dvs;
  logic [6:0]  rem;
  logic [5:0]  r2;
  logic [4:0]  cnt;
  logic [5:0]  sel_idx;

  // glide datapath
  logic        g_neg;
  logic [31:0] g_mag, g_tgt, g_cur;
  logic [47:0] g_prod;

  logic        slot_ok, scn_ok;
  logic [5:0]  ll;
  logic [6:0]  sl;
  logic [33:0] diff;
  logic [SAW-1:0] scale_wa, scale_ra;
  logic [NIW-1:0] note_idx;
  logic [7:0]  remw;
  logic        qbit;
  logic [6:0]  rem_next;
  logic [6:0]  r2w;
  logic [5:0]  r2_next;
  logic        freq_we;
  logic [31:0] freq_wd, g_new, g_stp;
  logic [3:0]  sel_scale;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);

  // decode of the held item
  always_comb begin
    slot_ok  = (8'(it.slot) < 8'(NUM_NOTES));
    scn_ok   = (it.scale_number != 4'd0) && (5'(it.scale_number) <= 5'(NUM_SCALES));
    ll       = (loop_length == 6'd0) ? 6'd1 : loop_length;
    sl       = (step_length == 7'd0) ? 7'd1 : step_length;
    note_idx = it.slot[NIW-1:0];
    scale_wa = SAW'((SAW'(it.scale_number) - SAW'(1)) * SAW'(NUM_NOTES) + SAW'(note_idx));
    scale_ra = SAW'((SAW'(active_scale) - SAW'(1)) * SAW'(NUM_NOTES) + SAW'(note_idx));
    if (measure_mode == ssg_pkg::ModeBeats) begin
      diff = 34'(it.beat_position) - 34'($signed(position_offset));
    end else begin
      diff = 34'($signed({it.bar_position, 8'd0})) - 34'($signed(position_offset));
    end
  end

  // one step of restoring division, quotient bit folded into the modulo
  always_comb begin
    remw     = {rem, dvd[24]};
    qbit     = (remw >= {1'b0, dvs});
    rem_next = qbit ? 7'(remw - {1'b0, dvs}) : remw[6:0];
    r2w      = {r2, qbit};
    r2_next  = (r2w >= {1'b0, ll}) ? 6'(r2w - {1'b0, ll}) : r2w[5:0];
  end

  // glide update and frequency write port
  always_comb begin
    g_stp = g_prod[47:16];
    if (g_mag < ssg_pkg::SnapLimit) begin
      g_new = g_tgt;
    end else if (g_neg) begin
      g_new = g_cur - g_stp;
    end else begin
      g_new = g_cur + g_stp;
    end
    freq_we = 1'b0;
    freq_wd = it.frequency_value;
    if (state == ST_EXEC && it.kind == ssg_pkg::KindLoadScale && scn_ok && slot_ok
        && it.scale_number == 4'd1) begin
      freq_we = 1'b1;
    end else if (state == ST_GWR) begin
      freq_we = 1'b1;
      freq_wd = g_new;
    end
    sel_scale = step_table[sel_idx[SIW-1:0]];
  end

  // memories: read every cycle, write on demand
  always_ff @(posedge clk) begin
    scale_rd <= scale_mem[scale_ra];
    freq_rd  <= freq_mem[note_idx];
    if (state == ST_EXEC && it.kind == ssg_pkg::KindLoadScale && scn_ok && slot_ok) begin
      scale_mem[scale_wa] <= it.frequency_value;
    end
    if (freq_we) begin
      freq_mem[note_idx] <= freq_wd;
    end
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      measure_mode    <= 2'd0;
      loop_length     <= 6'd32;
      step_length     <= 7'd1;
      position_offset <= 17'd0;
      glide_factor    <= 16'd65;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ssg_pkg::RegMeasureMode: measure_mode    <= cfg_data[1:0];
        ssg_pkg::RegLoopLength:  loop_length     <= cfg_data[5:0];
        ssg_pkg::RegStepLength:  step_length     <= cfg_data[6:0];
        ssg_pkg::RegPositionOfs: position_offset <= cfg_data[16:0];
        ssg_pkg::RegGlideFactor: glide_factor    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      result_valid  <= 1'b0;
      step_position <= 6'd0;
      active_scale  <= 4'd1;
      neg           <= 1'b0;
      for (int i = 0; i < NUM_STEPS; i++) begin
        step_table[i] <= 4'd0;
      end
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            it    <= item;
            neg   <= 1'b0;
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= ST_RD;
          rem   <= 7'd0;
          r2    <= 6'd0;
          cnt   <= 5'(ssg_pkg::DivBits - 1);
          unique case (it.kind)
            ssg_pkg::KindLoadStep: begin
              if (7'(it.slot) < 7'(NUM_STEPS)) begin
                step_table[it.slot[SIW-1:0]] <= it.scale_number;
              end
            end
            ssg_pkg::KindNoteOn: begin
              if (measure_mode == ssg_pkg::ModeNotes) begin
                dvd   <= 25'(step_position);
                dvs   <= 7'd1;
                state <= ST_DIV;
              end
            end
            ssg_pkg::KindPosition: begin
              if (measure_mode == ssg_pkg::ModeFirst) begin
                step_position <= 6'd1;
                sel_idx       <= 6'd0;
                state         <= ST_SEL;
              end else if (measure_mode != ssg_pkg::ModeNotes) begin
                if (diff[33]) begin
                  neg           <= 1'b1;
                  step_position <= 6'd0;
                end else begin
                  dvd   <= diff[32:8];
                  dvs   <= sl;
                  state <= ST_DIV;
                end
              end
            end
            ssg_pkg::KindGlide: begin
              if (slot_ok) state <= ST_GRD;
            end
            default: ;
          endcase
        end
        // advance one quotient bit per cycle
        ST_DIV: begin
          dvd <= {dvd[23:0], 1'b0};
          rem <= rem_next;
          r2  <= r2_next;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            sel_idx       <= r2_next;
            step_position <= r2_next + 6'd1;
            state         <= ST_SEL;
          end
        end
        ST_SEL: begin
          if (7'(sel_idx) < 7'(NUM_STEPS) && sel_scale != 4'd0
              && 5'(sel_scale) <= 5'(NUM_SCALES)) begin
            active_scale <= sel_scale;
          end
          state <= ST_RD;
        end
        ST_GRD: begin
          g_neg <= (scale_rd < freq_rd);
          g_mag <= (scale_rd < freq_rd) ? freq_rd - scale_rd : scale_rd - freq_rd;
          g_tgt <= scale_rd;
          g_cur <= freq_rd;
          state <= ST_GMUL;
        end
        ST_GMUL: begin
          g_prod <= 48'(g_mag) * 48'(glide_factor);
          state  <= ST_GWR;
        end
        ST_GWR: state <= ST_RD;
        ST_RD:  state <= ST_RDW;
        ST_RDW: begin
          result_valid              <= 1'b1;
          result.step_number        <= step_position;
          result.note               <= it.slot;
          result.frequency          <= slot_ok ? freq_rd : 32'd0;
          result.position_negative  <= neg;
          state                     <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  `SSG_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)
  `SSG_ASSERT_NEXT(a_strobe_single, clk, rst, result_valid, !result_valid)
  `SSG_ASSERT_SAME(a_result_idle, clk, rst, result_valid, !busy)
  `SSG_ASSERT_SAME(a_neg_step, clk, rst, result_valid && result.position_negative,
                   result.step_number == 6'd0)

endmodule
